[sv/spm_pkg.sv]
package spm_pkg;

  localparam int LEN_W      = 6;
  localparam int SYM_W      = 8;
  localparam int WORD_W     = 64;
  localparam int WORD_COUNT = 4;
  localparam int CHARS_PER_WORD = WORD_W / SYM_W;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_3 = 3'd4;

  localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = 6'd1;

  typedef enum logic [1:0] {
    OUTCOME_NONE     = 2'd0,
    OUTCOME_EXTEND   = 2'd1,
    OUTCOME_FALLBACK = 2'd2
  } outcome_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[sv/streaming_prefix_progress_matcher.sv]
// Each input symbol is written into the queue, popped by the back end and registered in the
// output stage before its result appears on out_tdata.
// Throughput: one symbol per cycle while out_tready is high, set by the back-end mask update.
// A four-entry queue between the compare front end and the state back end absorbs stalls.
// Reset is synchronous and active low; it clears the match state, the queue and the
// output stage, and returns the pattern length to one and the pattern words to zero.
module streaming_prefix_progress_matcher #(
  parameter int PATTERN_MAX = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spm_pkg::WORD_W-1:0]       cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] symbol
  input  logic [spm_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [5:0] longest_partial, [7:6] outcome, [13:8] best_ever, [14] found, [15] zero
  output logic [spm_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import spm_pkg::*;

  queue_status_t          q_status;
  logic                   q_push;
  logic                   q_pop;
  logic [PATTERN_MAX-1:0] push_hits;
  logic [PATTERN_MAX-1:0] pop_hits;
  logic [LEN_W-1:0]       len_eff;
  logic [LEN_W-1:0]       out_longest;
  outcome_t               out_outcome;
  logic [LEN_W-1:0]       out_best;
  logic                   out_found;

  spm_front #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_symbol (in_tdata[SYM_W-1:0]),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_hits    (push_hits),
    .len_eff   (len_eff)
  );

  spm_queue #(
    .WIDTH(PATTERN_MAX),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_hits),
    .pop       (q_pop),
    .pop_data  (pop_hits),
    .status    (q_status)
  );

  spm_back #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_status    (q_status),
    .q_hits      (pop_hits),
    .q_pop       (q_pop),
    .len_eff     (len_eff),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_longest (out_longest),
    .out_outcome (out_outcome),
    .out_best    (out_best),
    .out_found   (out_found)
  );

  assign out_tdata = {1'b0, out_found, out_best, out_outcome, out_longest};

endmodule

[sv/spm_front.sv]
module spm_front #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [spm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spm_pkg::WORD_W-1:0]    cfg_data,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [spm_pkg::SYM_W-1:0]     in_symbol,
  input  spm_pkg::queue_status_t       q_status,
  output logic                         q_push,
  output logic [PATTERN_MAX-1:0]       q_hits,
  output logic [spm_pkg::LEN_W-1:0]     len_eff
);
  import spm_pkg::*;

  logic [LEN_W-1:0]  len_r;
  logic [WORD_W-1:0] word_r [WORD_COUNT];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= PATTERN_LENGTH_RESET;
      for (int w = 0; w < WORD_COUNT; w++) begin
        word_r[w] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PATTERN_LENGTH: len_r <= cfg_data[LEN_W-1:0];
        CFG_PATTERN_WORD_0: word_r[0] <= cfg_data;
        CFG_PATTERN_WORD_1: word_r[1] <= cfg_data;
        CFG_PATTERN_WORD_2: word_r[2] <= cfg_data;
        CFG_PATTERN_WORD_3: word_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_W'(PATTERN_MAX)) begin
      len_eff = LEN_W'(PATTERN_MAX);
    end else begin
      len_eff = len_r;
    end
  end

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      q_hits[i] = (word_r[i / CHARS_PER_WORD][(i % CHARS_PER_WORD) * SYM_W +: SYM_W]
                   == in_symbol) && (LEN_W'(i) < len_eff);
    end
  end

  assign in_tready = !q_status.full;
  assign q_push    = in_tvalid && in_tready;

endmodule

[sv/spm_queue.sv]
module spm_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [WIDTH-1:0]       push_data,
  input  logic                   pop,
  output logic [WIDTH-1:0]       pop_data,
  output spm_pkg::queue_status_t status
);
  import spm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign status.full  = (cnt_r == CW'(DEPTH));
  assign status.empty = (cnt_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/spm_back.sv]
module spm_back #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spm_pkg::queue_status_t        q_status,
  input  logic [PATTERN_MAX-1:0]        q_hits,
  output logic                          q_pop,
  input  logic [spm_pkg::LEN_W-1:0]      len_eff,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [spm_pkg::LEN_W-1:0]      out_longest,
  output spm_pkg::outcome_t             out_outcome,
  output logic [spm_pkg::LEN_W-1:0]      out_best,
  output logic                          out_found
);
  import spm_pkg::*;

  logic [PATTERN_MAX-1:0] active_r, active_nxt;
  logic [LEN_W-1:0]       prev_r, prev_nxt;
  logic [LEN_W-1:0]       best_r, best_nxt;
  logic                   done_r, done_nxt;
  logic                   valid_r;
  logic [LEN_W-1:0]       longest_r;
  outcome_t               outcome_r, outcome_nxt;
  logic [PATTERN_MAX-1:0] mask;
  logic [LEN_W-1:0]       longest;

  assign q_pop = !q_status.empty && (!valid_r || out_tready);

  always_comb begin
    mask    = {active_r[PATTERN_MAX-1:0] << 1} | PATTERN_MAX'(1);
    mask    = mask & q_hits;
    longest = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (mask[i]) begin
        longest = LEN_W'(i + 1);
      end
    end
  end

  always_comb begin
    active_nxt  = active_r;
    prev_nxt    = prev_r;
    best_nxt    = best_r;
    done_nxt    = done_r;
    outcome_nxt = OUTCOME_NONE;
    if (!done_r) begin
      active_nxt = mask;
      prev_nxt   = longest;
      if (longest > best_r) begin
        best_nxt = longest;
      end
      if (longest == len_eff) begin
        done_nxt = 1'b1;
      end
      if (longest == prev_r + LEN_W'(1)) begin
        outcome_nxt = OUTCOME_EXTEND;
      end else if (longest != '0) begin
        outcome_nxt = OUTCOME_FALLBACK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      prev_r   <= '0;
      best_r   <= '0;
      done_r   <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        active_r <= active_nxt;
        prev_r   <= prev_nxt;
        best_r   <= best_nxt;
        done_r   <= done_nxt;
        valid_r  <= 1'b1;
      end else if (out_tready) begin
        valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      longest_r <= prev_nxt;
      outcome_r <= outcome_nxt;
    end
  end

  assign out_tvalid  = valid_r;
  assign out_longest = longest_r;
  assign out_outcome = outcome_r;
  assign out_best    = best_r;
  assign out_found   = done_r;

endmodule

[sv/spm_checker.sv]
module spm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [spm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import spm_pkg::*;

  logic       xfer;
  logic       found_seen_r;
  logic [5:0] longest;
  logic [1:0] outcome;
  logic [5:0] best;
  logic       found;

  assign xfer    = out_tvalid && out_tready;
  assign longest = out_tdata[5:0];
  assign outcome = out_tdata[7:6];
  assign best    = out_tdata[13:8];
  assign found   = out_tdata[14];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_seen_r <= 1'b0;
    end else if (xfer && found) begin
      found_seen_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Result changed while stalled.");

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |-> best >= longest)
    else $error("Best prefix below current prefix.");

  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |-> ((outcome == OUTCOME_NONE) || (longest != '0))
             && (outcome != 2'd3))
    else $error("Outcome does not fit the prefix length.");

  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && found_seen_r |-> found && (outcome == OUTCOME_NONE))
    else $error("State moved after the query was found.");

endmodule

bind streaming_prefix_progress_matcher spm_checker u_spm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
